FILE: rtl/hepe_pkg.sv
// ============================================================================
// hepe_pkg
// Shared widths, register map and defaults for the even-parity Hamming encoder.
// ============================================================================
package hepe_pkg;

    localparam int DATA_W    = 57;
    localparam int CODE_W    = 63;
    localparam int LEN_W     = 6;
    localparam int PCNT_W    = 3;
    localparam int PARITY_N  = 6;

    localparam int MAX_DATA_BITS_DEF = 57;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_DATA_LENGTH = 1'd0;
    localparam logic [LEN_W-1:0]   DATA_LENGTH_RST = 6'd4;

endpackage

FILE: rtl/hepe_if.sv
// ============================================================================
// hepe_in_if / hepe_out_if
// Valid/ready channels carrying data words in and encoded codewords out.
// ============================================================================
interface hepe_in_if;
    logic                          valid;
    logic                          ready;
    logic [hepe_pkg::DATA_W-1:0]   data_bits;

    modport source (output valid, output data_bits, input ready);
    modport sink   (input valid, input data_bits, output ready);
endinterface

interface hepe_out_if;
    logic                          valid;
    logic                          ready;
    logic [hepe_pkg::CODE_W-1:0]   codeword;
    logic [hepe_pkg::LEN_W-1:0]    codeword_length;
    logic [hepe_pkg::PCNT_W-1:0]   parity_count;

    modport source (output valid, output codeword, output codeword_length,
                    output parity_count, input ready);
    modport sink   (input valid, input codeword, input codeword_length,
                    input parity_count, output ready);
endinterface

FILE: rtl/hepe_regs.sv
// ============================================================================
// hepe_regs
// APB register block holding the data_length setting.
// ============================================================================
module hepe_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hepe_pkg::PADDR_W-1:0]  paddr,
    input  logic [hepe_pkg::PDATA_W-1:0]  pwdata,
    output logic [hepe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [hepe_pkg::LEN_W-1:0]    data_length
);
    import hepe_pkg::*;

    logic [LEN_W-1:0]   data_length_reg;
    logic [LEN_W-1:0]   data_length_next;
    logic [PADDR_W-3:0] reg_index;
    logic               wr_en;

    // word index; the low two bits are not decoded
    assign reg_index = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_DATA_LENGTH);

    always_comb
    begin
        data_length_next = data_length_reg;
        if (wr_en)
        begin
            data_length_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= DATA_LENGTH_RST;
        end
        else
        begin
            data_length_reg <= data_length_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_DATA_LENGTH)
        begin
            prdata = {{(PDATA_W-LEN_W){1'b0}}, data_length_reg};
        end
    end

    assign data_length = data_length_reg;

endmodule

FILE: rtl/hamming_even_parity_encoder_core.sv
// ============================================================================
// hamming_even_parity_encoder_core
// Even-parity Hamming encoder: masks a data word to the configured length,
// spreads it over the non-power-of-two codeword positions and fills in the
// parity bits at positions 1, 2, 4, ... 32.
// ============================================================================
// Throughput: one beat per cycle; the three-stage pipeline (length/parity
// count, mask and scatter, parity trees) advances every stage whose successor
// is free, so a stalled output fills bubbles first and only then drops
// din.ready.
// Reset (rst_n low, async): all stage valid bits clear, data_length returns
// to 4. Payload registers are not reset.
// ============================================================================
module hamming_even_parity_encoder_core #(
    parameter int MAX_DATA_BITS = hepe_pkg::MAX_DATA_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hepe_pkg::PADDR_W-1:0]  paddr,
    input  logic [hepe_pkg::PDATA_W-1:0]  pwdata,
    output logic [hepe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // streams
    hepe_in_if.sink                       din,
    hepe_out_if.source                    dout
);
    import hepe_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DATA_BITS);

    // smallest r with 2^r >= len + r + 1; len is at most 57, so r <= 6
    function automatic logic [PCNT_W-1:0] parity_count_for(input logic [LEN_W-1:0] len);
        logic [PCNT_W-1:0] res;
        res = PCNT_W'(PARITY_N);
        for (int r = PARITY_N; r >= 1; r--)
        begin
            if ((1 << r) >= (int'(len) + r + 1))
            begin
                res = PCNT_W'(r);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0] data_length;

    hepe_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .data_length (data_length)
    );

    // ------------------------------------------------------------------------
    // Pipeline handshake: a stage may load when it is empty or its content
    // moves on in the same cycle.
    // ------------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;
    logic in_beat;

    assign s3_ready  = !s3_valid_reg || dout.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign din.ready = s1_ready;
    assign in_beat   = din.valid && s1_ready;

    // ------------------------------------------------------------------------
    // Stage 1: clamp the length and derive r and n. The raw word and the
    // clamped length travel on to stage 2.
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]  len_eff;
    logic [PCNT_W-1:0] pcnt_s0;

    always_comb
    begin
        if (data_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (data_length > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = data_length;
        end
        pcnt_s0 = parity_count_for(len_eff);
    end

    logic [DATA_W-1:0] s1_data_reg,  s1_data_next;
    logic [LEN_W-1:0]  s1_len_reg,   s1_len_next;
    logic [LEN_W-1:0]  s1_n_reg,     s1_n_next;
    logic [PCNT_W-1:0] s1_r_reg,     s1_r_next;

    assign s1_data_next = din.data_bits;
    assign s1_len_next  = len_eff;
    assign s1_n_next    = len_eff + LEN_W'(pcnt_s0);
    assign s1_r_next    = pcnt_s0;

    // ------------------------------------------------------------------------
    // Stage 2: drop data bits past the length, then spread the rest over the
    // non-power-of-two positions. Once masked, the data bits land exactly in
    // positions 1..n; parity slots stay zero here.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] data_masked;
    logic [CODE_W-1:0] scatter_word;

    always_comb
    begin
        for (int i = 0; i < DATA_W; i++)
        begin
            data_masked[i] = s1_data_reg[i] && (i < int'(s1_len_reg));
        end
    end

    always_comb
    begin
        int nxt;
        nxt = 0;
        scatter_word = '0;
        for (int pos = 1; pos <= CODE_W; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                if (nxt < DATA_W)
                begin
                    scatter_word[pos-1] = data_masked[nxt];
                end
                nxt++;
            end
        end
    end

    logic [CODE_W-1:0] s2_word_reg, s2_word_next;
    logic [LEN_W-1:0]  s2_n_reg,    s2_n_next;
    logic [PCNT_W-1:0] s2_r_reg,    s2_r_next;

    assign s2_word_next = scatter_word;
    assign s2_n_next    = s1_n_reg;
    assign s2_r_next    = s1_r_reg;

    // ------------------------------------------------------------------------
    // Stage 3: six XOR trees. Parity k covers every position with bit k set;
    // other parity slots never have bit k set and are zero anyway. Positions
    // past n are zero, so parity bits beyond r come out zero as required.
    // ------------------------------------------------------------------------
    logic [CODE_W-1:0] coded_word;

    always_comb
    begin
        logic p;
        coded_word = s2_word_reg;
        for (int k = 0; k < PARITY_N; k++)
        begin
            p = 1'b0;
            for (int pos = 1; pos <= CODE_W; pos++)
            begin
                if (((pos >> k) & 1) != 0)
                begin
                    p = p ^ s2_word_reg[pos-1];
                end
            end
            coded_word[(1 << k) - 1] = p;
        end
    end

    logic [CODE_W-1:0] s3_word_reg, s3_word_next;
    logic [LEN_W-1:0]  s3_n_reg,    s3_n_next;
    logic [PCNT_W-1:0] s3_r_reg,    s3_r_next;

    assign s3_word_next = coded_word;
    assign s3_n_next    = s2_n_reg;
    assign s3_r_next    = s2_r_reg;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic s1_valid_next, s2_valid_next, s3_valid_next;

    assign s1_valid_next = s1_ready ? din.valid    : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_data_reg <= s1_data_next;
            s1_len_reg  <= s1_len_next;
            s1_n_reg    <= s1_n_next;
            s1_r_reg    <= s1_r_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_word_reg <= s2_word_next;
            s2_n_reg    <= s2_n_next;
            s2_r_reg    <= s2_r_next;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_word_reg <= s3_word_next;
            s3_n_reg    <= s3_n_next;
            s3_r_reg    <= s3_r_next;
        end
    end

    assign dout.valid           = s3_valid_reg;
    assign dout.codeword        = s3_word_reg;
    assign dout.codeword_length = s3_n_reg;
    assign dout.parity_count    = s3_r_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // a stage holding an item that cannot move keeps it
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("stage 1 item lost under stall");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_ready) |=> (s2_valid_reg && $stable(s2_word_reg)))
        else $error("stage 2 item lost under stall");

    // parity count stays in its legal range
    a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.parity_count == 3'd2 || dout.parity_count == 3'd3 ||
                        dout.parity_count == 3'd4 || dout.parity_count == 3'd5 ||
                        dout.parity_count == 3'd6))
        else $error("parity count out of range");

    // nothing is set above the codeword length
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> ((dout.codeword >> dout.codeword_length) == '0))
        else $error("codeword bits set past its length");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Even-parity Hamming encoder testbench
// Streams data words through the encoder under several data lengths, from a
// short directed set into long random runs with bursty input and a stalling
// output, and checks every codeword beat against its own encoder model.
// ----------------------------------------------------------------------------
module testbench;
    import hepe_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 4;    // pipeline is 3 deep, plus one spare
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 163;

    // Register map: register i sits at byte address 4*i
    localparam int                 SPARE_REG_INDEX = 1;    // nothing lives here
    localparam logic [PADDR_W-1:0] LEN_ADDR   = PADDR_W'(int'(REG_DATA_LENGTH) * 4);
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(SPARE_REG_INDEX * 4);

    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] CHECKER  = DATA_W'({(DATA_W + 1) / 2{2'b01}});

    // Output stall patterns
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

    typedef struct packed {
        logic [CODE_W-1:0] codeword;
        logic [LEN_W-1:0]  codeword_length;
        logic [PCNT_W-1:0] parity_count;
    } codeword_beat_t;

    // Holds the current data length and the codewords still owed by the DUT.
    class codeword_scoreboard;
        codeword_beat_t   expected_beats[$];
        logic [LEN_W-1:0] data_length;
        int               errors;

        function new();
            data_length = DATA_LENGTH_RST;
            errors      = 0;
        endfunction

        // Lengths of 0 act as 1, above the maximum they saturate.
        static function codeword_beat_t encode_word(logic [LEN_W-1:0] len_reg,
                                                    logic [DATA_W-1:0] data);
            codeword_beat_t beat;
            int   len;
            int   r;
            int   n;
            int   next_bit;
            int   pmask;
            logic par;
            len = int'(len_reg);
            if (len < 1)
            begin
                len = 1;
            end
            if (len > MAX_DATA_BITS_DEF)
            begin
                len = MAX_DATA_BITS_DEF;
            end
            r = 1;
            while ((1 << r) < len + r + 1)
            begin
                r++;
            end
            n             = len + r;
            next_bit      = 0;
            beat.codeword = '0;
            // data fills the non-power-of-two positions, lowest first
            for (int pos = 1; pos <= n; pos++)
            begin
                if ((pos & (pos - 1)) != 0)
                begin
                    beat.codeword[pos-1] = data[next_bit];
                    next_bit++;
                end
            end
            for (int k = 0; k < r; k++)
            begin
                pmask = 1 << k;
                par   = 1'b0;
                for (int pos = 1; pos <= n; pos++)
                begin
                    if ((pos & pmask) != 0 && pos != pmask)
                    begin
                        par ^= beat.codeword[pos-1];
                    end
                end
                beat.codeword[pmask-1] = par;
            end
            beat.codeword_length = LEN_W'(n);
            beat.parity_count    = PCNT_W'(r);
            return beat;
        endfunction

        function void note_word(logic [DATA_W-1:0] data);
            expected_beats.push_back(encode_word(data_length, data));
        endfunction

        function void check_beat(codeword_beat_t got);
            codeword_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: codeword %h", got.codeword);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.codeword !== want.codeword)
                begin
                    $error("codeword: expected %h, got %h", want.codeword, got.codeword);
                    errors++;
                end
                if (got.codeword_length !== want.codeword_length)
                begin
                    $error("codeword_length: expected %0d, got %0d",
                           want.codeword_length, got.codeword_length);
                    errors++;
                end
                if (got.parity_count !== want.parity_count)
                begin
                    $error("parity_count: expected %0d, got %0d",
                           want.parity_count, got.parity_count);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 cycle_count = 0;

    codeword_scoreboard sb = new();

    hepe_in_if  din_ch();
    hepe_out_if dout_ch();

    hamming_even_parity_encoder_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .din     (din_ch),
        .dout    (dout_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost codeword ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Beat monitor. Everything is driven on the falling edge, so values seen
    // here at the rising edge are the ones the DUT samples.
    // Output is checked before the input is noted; with the pipeline registers
    // between them the two never refer to the same word.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1)
            begin
                sb.check_beat(codeword_beat_t'{dout_ch.codeword,
                                               dout_ch.codeword_length,
                                               dout_ch.parity_count});
            end
            if (din_ch.valid === 1'b1 && din_ch.ready === 1'b1)
            begin
                sb.note_word(din_ch.data_bits);
            end
        end
    end

    // Output side backpressure: each span picks one stall pattern, from
    // always-ready down to mostly stalled, so stalls land on every stage.
    initial
    begin
        sink_mode_t mode;
        int         span;
        logic [7:0] stall_pat;
        dout_ch.ready <= 1'b0;
        forever
        begin
            mode      = sink_mode_t'($urandom_range(0, 3));
            span      = $urandom_range(16, 200);
            stall_pat = 8'($urandom_range(1, 255));
            for (int i = 0; i < span; i++)
            begin
                @(negedge clk);
                case (mode)
                    SINK_OPEN:
                    begin
                        dout_ch.ready <= 1'b1;
                    end
                    SINK_COIN:
                    begin
                        dout_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    SINK_SPARSE:
                    begin
                        dout_ch.ready <= ($urandom_range(0, 3) == 0);
                    end
                    default:
                    begin
                        dout_ch.ready <= stall_pat[i % 8];
                    end
                endcase
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return '0;
        end
        else if (pick == 1)
        begin
            return ALL_ONES;
        end
        return DATA_W'({$urandom(), $urandom()});
    endfunction

    // Mostly legal lengths; now and then zero or a length past the maximum.
    function automatic logic [LEN_W-1:0] random_length();
        int pick;
        int len;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            len = $urandom_range(MAX_DATA_BITS_DEF, (1 << LEN_W) - 1);
            if (len == MAX_DATA_BITS_DEF)
            begin
                len = 0;
            end
        end
        else if (pick == 1)
        begin
            len = ($urandom_range(0, 1) != 0) ? MAX_DATA_BITS_DEF : 1;
        end
        else
        begin
            len = $urandom_range(1, MAX_DATA_BITS_DEF);
        end
        return LEN_W'(len);
    endfunction

    // Called on a falling edge; returns on the falling edge after the beat
    // went in, with valid still high so back-to-back beats need no gap.
    task automatic send_word(input logic [DATA_W-1:0] data);
        din_ch.valid     <= 1'b1;
        din_ch.data_bits <= data;
        do
        begin
            @(posedge clk);
        end
        while (din_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // Drop valid and wait for every owed codeword, then let the pipe empty.
    task automatic wait_idle();
        din_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                  input logic [LEN_W-1:0]   want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (prdata !== PDATA_W'(want))
        begin
            $error("data_length: expected %0d, got %0d", want, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only reached with the DUT idle. Upper pwdata bits are junk the
    // register must drop.
    task automatic set_length(input logic [LEN_W-1:0] len);
        logic [PDATA_W-1:0] value;
        wait_idle();
        value              = $urandom();
        value[LEN_W-1:0]   = len;
        apb_write(LEN_ADDR, value);
        sb.data_length     = len;
        apb_read_check(LEN_ADDR, len);
    endtask

    // Random words in bursts with random gaps; some bursts run long with no
    // gap at all to keep the pipe full.
    task automatic send_random_phase(input int count);
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                gap   = $urandom_range(0, 5);
                if ($urandom_range(0, 7) == 0)
                begin
                    burst = $urandom_range(40, 120);
                end
                if (gap != 0)
                begin
                    din_ch.valid     <= 1'b0;
                    din_ch.data_bits <= random_word();
                    repeat (gap) @(negedge clk);
                end
            end
            send_word(random_word());
            burst--;
        end
    endtask

    initial
    begin
        // parity-count boundaries, both ends of the field, and lengths that
        // must clamp (zero, above the maximum)
        int edge_lengths[12] = '{1, 2, 3, 5, 11, 12, 26, 27, 57, 0, 63, 58};
        logic [LEN_W-1:0] len;

        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        din_ch.valid     <= 1'b0;
        din_ch.data_bits <= '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset length of 4; set bits above the length must not leak in.
        send_word('0);
        send_word(ALL_ONES);
        send_word(DATA_W'(5));
        send_word(CHECKER);

        // A write to an unmapped register changes nothing.
        wait_idle();
        apb_write(SPARE_ADDR, PDATA_W'(MAX_DATA_BITS_DEF));
        apb_read_check(LEN_ADDR, DATA_LENGTH_RST);
        send_word(ALL_ONES);

        foreach (edge_lengths[i])
        begin
            len = LEN_W'(edge_lengths[i]);
            set_length(len);
            send_word(ALL_ONES);
            if (len == 1 || len == MAX_DATA_BITS_DEF)
            begin
                send_word('0);
            end
            if (len == MAX_DATA_BITS_DEF)
            begin
                send_word(CHECKER);
                send_word(DATA_W'(1) << (DATA_W - 1));
            end
        end

        // Random phases; the first two pin the widest and narrowest words.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                len = LEN_W'(MAX_DATA_BITS_DEF);
            end
            else if (ph == 1)
            begin
                len = LEN_W'(1);
            end
            else
            begin
                len = random_length();
            end
            set_length(len);
            send_random_phase(WORDS_PER_PHASE);
        end

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
